[hdl/txsbh_pkg.sv]
// ----------------------------------------------------------------------------
// txsbh_pkg
// Shared types and constants of the transmit scheduler with broadcast
// hold-off: payload structs, result codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package txsbh_pkg;

  // Normal descriptor queue depth and the length limit.
  localparam int unsigned FifoDepth = 5;
  localparam int unsigned PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned SumW      = CntW + 1;
  localparam logic [7:0]  MaxLength = 8'd253;
  localparam logic [7:0]  PreambleBcast = 8'd1;

  // Configuration registers.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgHoldoffTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNormalGap    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBcastGap     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPollGap      = 2'd3;

  localparam logic [CfgDataW-1:0] HoldoffTicksRst = 16'd5000;
  localparam logic [CfgDataW-1:0] NormalGapRst    = 16'd100;
  localparam logic [CfgDataW-1:0] BcastGapRst     = 16'd1700;
  localparam logic [CfgDataW-1:0] PollGapRst      = 16'd100;

  // Input operation codes.
  typedef enum logic {
    OpEnqueue = 1'b0,
    OpTick    = 1'b1
  } op_e;

  // Result event codes.
  typedef enum logic [1:0] {
    EvEnqStatus  = 2'd0,
    EvSendNormal = 2'd1,
    EvSendBcast  = 2'd2
  } event_e;

  // Enqueue outcome codes.
  typedef enum logic [1:0] {
    StQueued      = 2'd0,
    StBcastStored = 2'd1,
    StDroppedFull = 2'd2,
    StTooLong     = 2'd3
  } status_e;

  // One input word.
  typedef struct packed {
    op_e        operation;
    logic [7:0] packet_ref;
    logic [7:0] length;
    logic       ack_req;
    logic [7:0] preamble_mode;
  } in_word_t;

  // One result word.
  typedef struct packed {
    event_e     event_res;
    status_e    status;
    logic [7:0] out_ref;
    logic [7:0] out_length;
    logic       out_ack_req;
    logic [7:0] out_preamble;
  } out_word_t;

  // Stored transmit descriptor.
  typedef struct packed {
    logic [7:0] preamble;
    logic       ack_req;
    logic [7:0] length;
    logic [7:0] pkt_ref;
  } desc_t;

endpackage

[hdl/tx_scheduler_broadcast_holdoff_core.sv]
// ----------------------------------------------------------------------------
// tx_scheduler_broadcast_holdoff_core
// Transmit descriptor scheduler with a normal FIFO and a broadcast slot that
// is held off while normal traffic keeps arriving.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on in_valid_i/in_ready_o. An enqueue word answers with
// one status word; a tick word answers with a send-normal word, a
// send-broadcast word or nothing. Result words leave on
// out_valid_o/out_ready_i. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while the block
// is idle, as the block itself does not enforce it. An accepted word waits
// in the input register until processed; its result is held in the result
// register and shown on out_data_o. Throughput: one word per cycle while the
// receiver takes results; input and result register are the only stages.
// While the receiver stalls, the result register holds its word; the input
// register still takes one more word, then in_ready_o drops until the
// result register frees up. Tick words that give no result also wait for it.
// Reset clears the queue, the broadcast flag and both countdowns and loads
// the register reset values; descriptor storage is not cleared.
// ----------------------------------------------------------------------------
module tx_scheduler_broadcast_holdoff_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  txsbh_pkg::in_word_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output txsbh_pkg::out_word_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [txsbh_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [txsbh_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [txsbh_pkg::CfgDataW-1:0] holdoff_ticks_q, normal_gap_q, bcast_gap_q, poll_gap_q;

  // Pipeline registers.
  logic                 in_valid_q;
  txsbh_pkg::in_word_t  in_q;
  logic                 out_valid_q;
  txsbh_pkg::out_word_t out_q;

  // Scheduler state.
  txsbh_pkg::desc_t                fifo_mem [txsbh_pkg::FifoDepth];
  logic [txsbh_pkg::PtrW-1:0]      head_q, head_d;
  logic [txsbh_pkg::CntW-1:0]      count_q, count_d;
  txsbh_pkg::desc_t                bcast_slot_q;
  logic                            bcast_wait_q, bcast_wait_d;
  logic [txsbh_pkg::CfgDataW-1:0]  holdoff_q, holdoff_d;
  logic [txsbh_pkg::CfgDataW-1:0]  pace_q, pace_d;

  // Processing controls.
  logic                       out_free;
  logic                       proc_go;
  logic                       res_valid;
  txsbh_pkg::out_word_t       res_word;
  txsbh_pkg::desc_t           in_desc;
  txsbh_pkg::desc_t           head_desc;
  logic                       fifo_wr;
  logic                       bcast_wr;
  logic [txsbh_pkg::PtrW-1:0] tail_idx;
  logic [txsbh_pkg::SumW-1:0] tail_sum;
  logic [txsbh_pkg::CfgDataW-1:0] pace_dec, holdoff_dec;

  // Handshake: the result register frees when empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign proc_go     = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || proc_go;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_ticks_q <= txsbh_pkg::HoldoffTicksRst;
      normal_gap_q    <= txsbh_pkg::NormalGapRst;
      bcast_gap_q     <= txsbh_pkg::BcastGapRst;
      poll_gap_q      <= txsbh_pkg::PollGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        txsbh_pkg::CfgHoldoffTicks: holdoff_ticks_q <= cfg_wdata_i;
        txsbh_pkg::CfgNormalGap:    normal_gap_q    <= cfg_wdata_i;
        txsbh_pkg::CfgBcastGap:     bcast_gap_q     <= cfg_wdata_i;
        txsbh_pkg::CfgPollGap:      poll_gap_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Descriptor views of the registered word and the queue head.
  assign in_desc.pkt_ref  = in_q.packet_ref;
  assign in_desc.length   = in_q.length;
  assign in_desc.ack_req  = in_q.ack_req;
  assign in_desc.preamble = in_q.preamble_mode;
  assign head_desc        = fifo_mem[head_q];

  // Tail slot: head plus count, wrapped once around the queue.
  always_comb begin
    tail_sum = txsbh_pkg::SumW'(head_q) + txsbh_pkg::SumW'(count_q);
    if (tail_sum >= txsbh_pkg::SumW'(txsbh_pkg::FifoDepth)) begin
      tail_sum = tail_sum - txsbh_pkg::SumW'(txsbh_pkg::FifoDepth);
    end
    tail_idx = tail_sum[txsbh_pkg::PtrW-1:0];
  end

  // Saturating countdowns for a tick.
  assign pace_dec    = (pace_q == '0) ? '0 : pace_q - 1'b1;
  assign holdoff_dec = (holdoff_q == '0) ? '0 : holdoff_q - 1'b1;

  // Scheduling decision for the registered word.
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    bcast_wait_d = bcast_wait_q;
    holdoff_d    = holdoff_q;
    pace_d       = pace_q;
    fifo_wr      = 1'b0;
    bcast_wr     = 1'b0;
    res_valid    = 1'b0;
    res_word     = '0;

    if (in_q.operation == txsbh_pkg::OpEnqueue) begin
      res_valid          = 1'b1;
      res_word.event_res = txsbh_pkg::EvEnqStatus;
      if (in_q.length >= txsbh_pkg::MaxLength) begin
        res_word.status = txsbh_pkg::StTooLong;
      end else if (in_q.preamble_mode == txsbh_pkg::PreambleBcast) begin
        bcast_wr        = 1'b1;
        bcast_wait_d    = 1'b1;
        holdoff_d       = holdoff_ticks_q;
        res_word.status = txsbh_pkg::StBcastStored;
      end else if (count_q >= txsbh_pkg::CntW'(txsbh_pkg::FifoDepth)) begin
        res_word.status = txsbh_pkg::StDroppedFull;
      end else begin
        fifo_wr         = 1'b1;
        count_d         = count_q + 1'b1;
        if (bcast_wait_q) begin
          holdoff_d = holdoff_ticks_q;
        end
        res_word.status = txsbh_pkg::StQueued;
      end
    end else begin
      pace_d    = pace_dec;
      holdoff_d = holdoff_dec;
      if (pace_dec == '0) begin
        if (count_q != '0) begin
          // Queued normal traffic goes first.
          count_d                = count_q - 1'b1;
          head_d                 = (head_q == txsbh_pkg::PtrW'(txsbh_pkg::FifoDepth - 1))
                                   ? '0 : head_q + 1'b1;
          pace_d                 = normal_gap_q;
          res_valid              = 1'b1;
          res_word.event_res     = txsbh_pkg::EvSendNormal;
          res_word.status        = txsbh_pkg::StQueued;
          res_word.out_ref       = head_desc.pkt_ref;
          res_word.out_length    = head_desc.length;
          res_word.out_ack_req   = head_desc.ack_req;
          res_word.out_preamble  = head_desc.preamble;
        end else if (bcast_wait_q && holdoff_dec == '0) begin
          // Broadcast once the hold-off has run out.
          bcast_wait_d           = 1'b0;
          pace_d                 = bcast_gap_q;
          res_valid              = 1'b1;
          res_word.event_res     = txsbh_pkg::EvSendBcast;
          res_word.status        = txsbh_pkg::StQueued;
          res_word.out_ref       = bcast_slot_q.pkt_ref;
          res_word.out_length    = bcast_slot_q.length;
          res_word.out_ack_req   = bcast_slot_q.ack_req;
          res_word.out_preamble  = bcast_slot_q.preamble;
        end else begin
          // Nothing eligible: wait one poll interval.
          pace_d = poll_gap_q;
        end
      end
    end
  end

  // Control state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      bcast_wait_q <= 1'b0;
      holdoff_q    <= '0;
      pace_q       <= '0;
    end else if (proc_go) begin
      head_q       <= head_d;
      count_q      <= count_d;
      bcast_wait_q <= bcast_wait_d;
      holdoff_q    <= holdoff_d;
      pace_q       <= pace_d;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk_i) begin
    if (proc_go && fifo_wr) begin
      fifo_mem[tail_idx] <= in_desc;
    end
    if (proc_go && bcast_wr) begin
      bcast_slot_q <= in_desc;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && res_valid) begin
      out_q <= res_word;
    end
  end

`ifndef SYNTH
  // The queue never holds more descriptors than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= txsbh_pkg::CntW'(txsbh_pkg::FifoDepth))
    else $error("descriptor count exceeds queue depth");

  // Sending the broadcast retires the waiting flag.
  a_bcast_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && res_valid && res_word.event_res == txsbh_pkg::EvSendBcast)
    |=> !bcast_wait_q)
    else $error("broadcast still waiting after it was sent");

  // A held input word is not overwritten while processing stalls.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_go) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input word was lost or changed");

  // A normal send is only taken from a non-empty queue.
  a_send_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && res_valid && res_word.event_res == txsbh_pkg::EvSendNormal)
    |-> (count_q != '0))
    else $error("normal send from an empty queue");
`endif

endmodule

[tb/sv/tb_tx_scheduler_broadcast_holdoff_core.sv]
// ----------------------------------------------------------------------------
// tb_tx_scheduler_broadcast_holdoff_core
// Self-checking testbench for the transmit scheduler with broadcast hold-off.
// A scheduler model inside the bench predicts the status and send words. It
// covers directed corner cases, random traffic under several register
// settings, a long receiver stall that backs up the input, and idle-free
// stretches. Each result word is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_tx_scheduler_broadcast_holdoff_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver behavior while it is not in a forced hold.
  typedef enum logic [1:0] {
    RxAlways,
    RxRandom,
    RxPattern,
    RxSlow
  } rx_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  txsbh_pkg::in_word_t            in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  txsbh_pkg::out_word_t           out_data_o;
  logic                           cfg_we_i;
  logic [txsbh_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [txsbh_pkg::CfgDataW-1:0] cfg_wdata_i;

  // Scheduler model state and register copies.
  txsbh_pkg::desc_t q_store [txsbh_pkg::FifoDepth];
  int unsigned      q_head;
  int unsigned      q_count;
  txsbh_pkg::desc_t bc_slot;
  bit               bc_waiting;
  logic [15:0]      holdoff_cnt;
  logic [15:0]      pace_cnt;
  logic [15:0]      holdoff_ticks;
  logic [15:0]      normal_gap;
  logic [15:0]      bcast_gap;
  logic [15:0]      poll_gap;

  // Predicted result words, oldest first.
  txsbh_pkg::out_word_t sched_expect_q [$];
  int                   err_count = 0;

  // Sender burst control and receiver controls.
  bit             tx_idle_en;
  int unsigned    burst_left;
  rx_mode_e       rx_mode;
  int unsigned    rx_hold_req;

  tx_scheduler_broadcast_holdoff_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Build the send word for a descriptor leaving the scheduler.
  function automatic txsbh_pkg::out_word_t send_word_of(txsbh_pkg::event_e ev,
                                                        txsbh_pkg::desc_t d);
    txsbh_pkg::out_word_t r;
    r              = '0;
    r.event_res    = ev;
    r.status       = txsbh_pkg::StQueued;
    r.out_ref      = d.pkt_ref;
    r.out_length   = d.length;
    r.out_ack_req  = d.ack_req;
    r.out_preamble = d.preamble;
    return r;
  endfunction

  // Advance the scheduler model by one word and queue any result it gives.
  function automatic void predict_schedule(txsbh_pkg::in_word_t w);
    txsbh_pkg::out_word_t r;
    txsbh_pkg::desc_t     d;
    r = '0;
    if (w.operation == txsbh_pkg::OpEnqueue) begin
      d.pkt_ref  = w.packet_ref;
      d.length   = w.length;
      d.ack_req  = w.ack_req;
      d.preamble = w.preamble_mode;
      r.event_res = txsbh_pkg::EvEnqStatus;
      if (w.length >= txsbh_pkg::MaxLength) begin
        r.status = txsbh_pkg::StTooLong;
      end else if (w.preamble_mode == txsbh_pkg::PreambleBcast) begin
        bc_slot     = d;
        bc_waiting  = 1'b1;
        holdoff_cnt = holdoff_ticks;
        r.status    = txsbh_pkg::StBcastStored;
      end else if (q_count >= txsbh_pkg::FifoDepth) begin
        r.status = txsbh_pkg::StDroppedFull;
      end else begin
        q_store[(q_head + q_count) % txsbh_pkg::FifoDepth] = d;
        q_count++;
        // New normal traffic pushes the broadcast further out.
        if (bc_waiting) holdoff_cnt = holdoff_ticks;
        r.status = txsbh_pkg::StQueued;
      end
      sched_expect_q.push_back(r);
    end else begin
      if (pace_cnt != 0) pace_cnt--;
      if (holdoff_cnt != 0) holdoff_cnt--;
      if (pace_cnt == 0) begin
        if (q_count > 0) begin
          d        = q_store[q_head];
          q_head   = (q_head + 1) % txsbh_pkg::FifoDepth;
          q_count--;
          pace_cnt = normal_gap;
          sched_expect_q.push_back(send_word_of(txsbh_pkg::EvSendNormal, d));
        end else if (bc_waiting && holdoff_cnt == 0) begin
          bc_waiting = 1'b0;
          pace_cnt   = bcast_gap;
          sched_expect_q.push_back(send_word_of(txsbh_pkg::EvSendBcast, bc_slot));
        end else begin
          pace_cnt = poll_gap;
        end
      end
    end
  endfunction

  function automatic txsbh_pkg::in_word_t enq_word(logic [7:0] pref, logic [7:0] len,
                                                   logic ack, logic [7:0] pre);
    txsbh_pkg::in_word_t w;
    w.operation     = txsbh_pkg::OpEnqueue;
    w.packet_ref    = pref;
    w.length        = len;
    w.ack_req       = ack;
    w.preamble_mode = pre;
    return w;
  endfunction

  // Random word; tick payload fields are random too since the block ignores them.
  function automatic txsbh_pkg::in_word_t rand_word(int unsigned tick_pct);
    txsbh_pkg::in_word_t w;
    w.operation  = ($urandom_range(0, 99) < tick_pct) ? txsbh_pkg::OpTick
                                                      : txsbh_pkg::OpEnqueue;
    w.packet_ref = 8'($urandom_range(0, 255));
    w.ack_req    = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) w.length = 8'($urandom_range(253, 255));
    else w.length = 8'($urandom_range(0, 252));
    if ($urandom_range(0, 4) == 0) w.preamble_mode = txsbh_pkg::PreambleBcast;
    else w.preamble_mode = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Offer one word and wait for its handshake. Called at a falling edge,
  // returns at a falling edge with valid still high.
  task automatic send_word(txsbh_pkg::in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = tx_idle_en ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_schedule(w);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every predicted word, then let the pipeline
  // settle so that silent ticks are also done.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sched_expect_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write all four registers, one per cycle; only called while idle.
  task automatic write_config(logic [15:0] hold, logic [15:0] ngap, logic [15:0] bgap,
                              logic [15:0] pgap);
    logic [txsbh_pkg::CfgDataW-1:0] vals [4];
    logic [txsbh_pkg::CfgIdxW-1:0]  idxs [4];
    vals = '{hold, ngap, bgap, pgap};
    idxs = '{txsbh_pkg::CfgHoldoffTicks, txsbh_pkg::CfgNormalGap,
             txsbh_pkg::CfgBcastGap, txsbh_pkg::CfgPollGap};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idxs[i];
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    holdoff_ticks = hold;
    normal_gap    = ngap;
    bcast_gap     = bgap;
    poll_gap      = pgap;
    @(negedge clk_i);
  endtask

  task automatic run_traffic(int unsigned n_words, int unsigned tick_pct);
    repeat (n_words) send_word(rand_word(tick_pct));
  endtask

  // Corner cases: length limits, broadcast replace, full queue, hold-off
  // restart, zero gaps and nothing-eligible polls.
  task automatic test_directed();
    txsbh_pkg::in_word_t tick_w;
    tick_w           = '1;
    tick_w.operation = txsbh_pkg::OpTick;
    write_config(16'd3, 16'd0, 16'd1, 16'd0);
    send_word(tick_w);
    send_word(enq_word(8'h00, 8'd253, 1'b0, 8'h00));
    send_word(enq_word(8'hFF, 8'd255, 1'b1, 8'hFF));
    send_word(enq_word(8'hFF, 8'd252, 1'b1, txsbh_pkg::PreambleBcast));
    send_word(enq_word(8'hAA, 8'd0, 1'b0, txsbh_pkg::PreambleBcast));
    send_word(enq_word(8'h00, 8'd252, 1'b1, 8'h00));
    send_word(enq_word(8'hFF, 8'd0, 1'b0, 8'hFF));
    send_word(enq_word(8'h55, 8'd128, 1'b1, 8'h02));
    send_word(enq_word(8'h80, 8'd127, 1'b0, 8'h80));
    send_word(enq_word(8'h7F, 8'd1, 1'b1, 8'h7F));
    send_word(enq_word(8'h33, 8'd10, 1'b0, 8'h00));
    repeat (9) send_word(tick_w);
    drain_results();
  endtask

  // All registers at zero: every tick decides, gaps act as one.
  task automatic test_zero_config();
    write_config(16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(100, 50);
    drain_results();
  endtask

  // Random traffic under several small settings and receiver styles.
  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      write_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
      rx_mode = rx_mode_e'(p % 4);
      run_traffic(160, 35 + 5 * p);
      drain_results();
    end
  endtask

  // Long receiver stall while the sender keeps offering, then a full pause.
  task automatic test_backpressure();
    write_config(16'd2, 16'd1, 16'd2, 16'd1);
    rx_mode     = RxRandom;
    tx_idle_en  = 1'b0;
    rx_hold_req = 400;
    run_traffic(80, 30);
    drain_results();
    tx_idle_en  = 1'b1;
  endtask

  // No idling on either side.
  task automatic test_no_idle();
    write_config(16'd4, 16'd1, 16'd3, 16'd2);
    rx_mode    = RxAlways;
    tx_idle_en = 1'b0;
    run_traffic(150, 50);
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  // Reset-value and maximum settings; they load long countdowns, so they run last.
  task automatic test_large_config();
    rx_mode = RxPattern;
    write_config(txsbh_pkg::HoldoffTicksRst, txsbh_pkg::NormalGapRst,
                 txsbh_pkg::BcastGapRst, txsbh_pkg::PollGapRst);
    run_traffic(100, 50);
    drain_results();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(100, 50);
    drain_results();
  endtask

  // Receiver: forced hold first, otherwise the current stall style.
  initial begin
    int unsigned hold_left;
    int unsigned phase;
    hold_left   = 0;
    phase       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req - 1;
        rx_hold_req = 0;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways:  out_ready_i <= 1'b1;
          RxRandom:  out_ready_i <= ($urandom_range(0, 3) != 0);
          RxPattern: out_ready_i <= ((phase % 7) < 3);
          default:   out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    txsbh_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_expect_q.size() == 0) begin
        $error("result word %h with no prediction waiting", out_data_o);
        err_count++;
      end else begin
        exp_w = sched_expect_q.pop_front();
        if (out_data_o.event_res !== exp_w.event_res) begin
          $error("event_res: expected %0d, actual %0d", exp_w.event_res, out_data_o.event_res);
          err_count++;
        end
        if (out_data_o.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_data_o.status);
          err_count++;
        end
        if (out_data_o.out_ref !== exp_w.out_ref) begin
          $error("out_ref: expected %0d, actual %0d", exp_w.out_ref, out_data_o.out_ref);
          err_count++;
        end
        if (out_data_o.out_length !== exp_w.out_length) begin
          $error("out_length: expected %0d, actual %0d", exp_w.out_length,
                 out_data_o.out_length);
          err_count++;
        end
        if (out_data_o.out_ack_req !== exp_w.out_ack_req) begin
          $error("out_ack_req: expected %0d, actual %0d", exp_w.out_ack_req,
                 out_data_o.out_ack_req);
          err_count++;
        end
        if (out_data_o.out_preamble !== exp_w.out_preamble) begin
          $error("out_preamble: expected %0d, actual %0d", exp_w.out_preamble,
                 out_data_o.out_preamble);
          err_count++;
        end
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    tx_idle_en    = 1'b1;
    burst_left    = 0;
    rx_mode       = RxRandom;
    rx_hold_req   = 0;
    q_head        = 0;
    q_count       = 0;
    bc_slot       = '0;
    bc_waiting    = 1'b0;
    holdoff_cnt   = '0;
    pace_cnt      = '0;
    holdoff_ticks = txsbh_pkg::HoldoffTicksRst;
    normal_gap    = txsbh_pkg::NormalGapRst;
    bcast_gap     = txsbh_pkg::BcastGapRst;
    poll_gap      = txsbh_pkg::PollGapRst;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_zero_config();
    test_random_traffic();
    test_backpressure();
    test_no_idle();
    test_large_config();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
